>>> rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants for the command line tokenizer
// Character classes, lexer state codes, token kinds, status codes and the
// queue entry and result records passed between the front and back parts.
// ----------------------------------------------------------------------------
package clt_pkg;

    // parameter defaults
    localparam int DEF_LINE_BITS   = 16;
    localparam int DEF_COLUMN_BITS = 16;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int DEF_QUEUE_DEPTH = 2;

    // character constants
    localparam logic [7:0] CH_NUL        = 8'd0;
    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_DQUOTE     = 8'd34;
    localparam logic [7:0] CH_HASH       = 8'd35;
    localparam logic [7:0] CH_SQUOTE     = 8'd39;
    localparam logic [7:0] CH_SEMICOLON  = 8'd59;
    localparam logic [7:0] CH_BACKSLASH  = 8'd92;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;

    // character classes
    localparam logic [2:0] CL_WHITE   = 3'd0;
    localparam logic [2:0] CL_QUOTE   = 3'd1;
    localparam logic [2:0] CL_SEP     = 3'd2;
    localparam logic [2:0] CL_ESCAPE  = 3'd3;
    localparam logic [2:0] CL_COMMENT = 3'd4;
    localparam logic [2:0] CL_TOKEN   = 3'd5;

    // lexer states
    localparam logic [2:0] ST_SEARCH  = 3'd0;
    localparam logic [2:0] ST_TOKEN   = 3'd1;
    localparam logic [2:0] ST_QUOTE   = 3'd2;
    localparam logic [2:0] ST_AFTERQ  = 3'd3;
    localparam logic [2:0] ST_SEP     = 3'd4;
    localparam logic [2:0] ST_COMMENT = 3'd5;
    localparam logic [2:0] ST_HALT    = 3'd6;

    // token kinds
    localparam logic [1:0] K_VALUE   = 2'd0;
    localparam logic [1:0] K_SEP     = 2'd1;
    localparam logic [1:0] K_QUOTE   = 2'd2;
    localparam logic [1:0] K_COMMENT = 2'd3;

    // status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_PENDING = 3'd1;
    localparam logic [2:0] STS_ESCAPE  = 3'd2;
    localparam logic [2:0] STS_QUOTE   = 3'd3;
    localparam logic [2:0] STS_CHAR    = 3'd4;
    localparam logic [2:0] STS_CLASS   = 3'd5;

    // classified character as held in the queue
    typedef struct packed {
        logic       is_end;
        logic       is_newline;
        logic       is_dquote;
        logic       is_squote;
        logic       is_ident;
        logic [2:0] cls;
    } t_clt_item;

    // one result record
    typedef struct packed {
        logic        put_terminator;
        logic        copy_char;
        logic        token_start;
        logic [1:0]  token_kind;
        logic        is_identifier;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] end_line;
        logic [15:0] end_column;
        logic [15:0] token_count;
        logic [2:0]  status;
        logic        string_done;
    } t_clt_result;

    // character class lookup
    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] cl;
        cl = CL_TOKEN;
        if (c <= CH_SPACE) begin
            cl = CL_WHITE;
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            cl = CL_QUOTE;
        end else if (c == CH_BACKSLASH) begin
            cl = CL_ESCAPE;
        end else if (c == CH_HASH) begin
            cl = CL_COMMENT;
        end else begin
            case (c) inside
                CH_SEMICOLON, 8'd61, 8'd63, 8'd46, 8'd33, 8'd64, 8'd36, 8'd37,
                8'd94, 8'd38, 8'd42, 8'd43, 8'd45, 8'd126, 8'd96, 8'd124,
                8'd58, 8'd44, 8'd47, 8'd123, 8'd125, 8'd40, 8'd41, 8'd60,
                8'd62, 8'd91, 8'd93: cl = CL_SEP;
                default: cl = CL_TOKEN;
            endcase
        end
        return cl;
    endfunction

    // letter or underscore
    function automatic logic starts_ident(input logic [7:0] c);
        return (c == CH_UNDERSCORE) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    // low 16 bits of a counter of up to 32 bits, zero extended
    function automatic logic [15:0] low16(input logic [31:0] v);
        return v[15:0];
    endfunction

endpackage

>>> rtl/clt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front: input side of the tokenizer
// Takes input transfers while the queue has room and classifies each byte
// into a compact queue entry.
// ----------------------------------------------------------------------------
module clt_front (
    input  logic                 i_valid,
    input  logic [7:0]           i_char,
    input  logic                 i_queue_full,
    output logic                 o_ready,
    output logic                 o_push,
    output clt_pkg::t_clt_item   o_item
);
    import clt_pkg::*;

    // accept while the queue has a free slot
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // classify the byte
    always_comb begin
        o_item.is_end     = (i_char == CH_NUL);
        o_item.is_newline = (i_char == CH_NEWLINE);
        o_item.is_dquote  = (i_char == CH_DQUOTE);
        o_item.is_squote  = (i_char == CH_SQUOTE);
        o_item.is_ident   = starts_ident(i_char);
        o_item.cls        = classify(i_char);
    end

endmodule

>>> rtl/clt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_queue: short queue between classifier and lexer
// Register based first-in first-out buffer of classified characters.
// ----------------------------------------------------------------------------
module clt_queue #(
    parameter int DEPTH = clt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  clt_pkg::t_clt_item   i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output clt_pkg::t_clt_item   o_data
);
    import clt_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_clt_item           r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/clt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_lexer: back part of the tokenizer
// Runs the lexer state machine on one queued character per cycle unless a result
// waits; keeps the position and token counters and holds the result in an output register.
// ----------------------------------------------------------------------------
module clt_lexer #(
    parameter int LINE_BITS   = clt_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = clt_pkg::DEF_COLUMN_BITS,
    parameter int COUNT_BITS  = clt_pkg::DEF_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  clt_pkg::t_clt_item   i_item,
    output logic                 o_item_pop,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output clt_pkg::t_clt_result o_res
);
    import clt_pkg::*;

    // lexer state
    logic [2:0]             r_state;
    logic                   r_dquote;
    logic                   r_esc_pend;
    logic                   r_nl_pend;
    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_col;
    logic [LINE_BITS-1:0]   r_rec_line;
    logic [COLUMN_BITS-1:0] r_rec_col;
    logic                   r_ident;
    logic [COUNT_BITS-1:0]  r_tokens;
    logic                   r_last_char;
    logic                   r_buf_empty;
    logic [2:0]             r_err;

    logic [2:0]             n_state;
    logic                   n_dquote;
    logic                   n_esc_pend;
    logic                   n_nl_pend;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] n_col;
    logic [LINE_BITS-1:0]   n_rec_line;
    logic [COLUMN_BITS-1:0] n_rec_col;
    logic                   n_ident;
    logic [COUNT_BITS-1:0]  n_tokens;
    logic                   n_last_char;
    logic                   n_buf_empty;
    logic [2:0]             n_err;

    // output register
    t_clt_result            r_out;
    logic                   r_out_valid;
    t_clt_result            res;

    // per character working values
    logic [LINE_BITS-1:0]   line_cur;
    logic [COLUMN_BITS-1:0] col_cur;
    logic [COLUMN_BITS-1:0] col_inc;
    logic                   delim;
    logic                   tok;
    logic [1:0]             kind;
    logic                   pop;

    assign pop         = i_item_valid && (!r_out_valid || i_res_ready);
    assign o_item_pop  = pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // line and column of the current character
    always_comb begin
        if (r_nl_pend) begin
            line_cur = (r_line == '1) ? r_line : r_line + 1'b1;
            col_cur  = '0;
        end else begin
            line_cur = r_line;
            col_cur  = r_col;
        end
        col_inc = (col_cur == '1) ? col_cur : col_cur + 1'b1;
    end

    // lexer transition and result
    always_comb begin
        n_state     = r_state;
        n_dquote    = r_dquote;
        n_esc_pend  = r_esc_pend;
        n_nl_pend   = r_nl_pend;
        n_line      = r_line;
        n_col       = r_col;
        n_rec_line  = r_rec_line;
        n_rec_col   = r_rec_col;
        n_ident     = r_ident;
        n_tokens    = r_tokens;
        n_last_char = r_last_char;
        n_buf_empty = r_buf_empty;
        n_err       = r_err;
        delim       = 1'b0;
        tok         = 1'b0;
        kind        = K_VALUE;
        res         = '0;

        if (i_item.is_end) begin
            // end of string: report and rearm
            res.put_terminator = r_buf_empty || r_last_char;
            res.token_count    = low16(32'(r_tokens));
            res.status         = (r_state != ST_HALT && r_state != ST_QUOTE) ? STS_OK : r_err;
            res.string_done    = 1'b1;
            n_state     = ST_SEARCH;
            n_dquote    = 1'b0;
            n_esc_pend  = 1'b0;
            n_nl_pend   = 1'b0;
            n_line      = '0;
            n_col       = '0;
            n_rec_line  = '0;
            n_rec_col   = '0;
            n_ident     = 1'b0;
            n_tokens    = '0;
            n_last_char = 1'b0;
            n_buf_empty = 1'b1;
            n_err       = STS_PENDING;
        end else if (r_state >= ST_HALT) begin
            // halted: ignore the character
            res.token_count = low16(32'(r_tokens));
            res.status      = r_err;
        end else begin
            unique case (r_state)
                ST_SEARCH: begin
                    case (i_item.cls)
                        CL_TOKEN: begin
                            tok = 1'b1; kind = K_VALUE; n_state = ST_TOKEN;
                            n_ident = i_item.is_ident;
                        end
                        CL_SEP: begin
                            delim = 1'b1; tok = 1'b1; kind = K_SEP; n_state = ST_SEP;
                        end
                        CL_QUOTE: begin
                            n_dquote = i_item.is_dquote;
                            tok = 1'b1; kind = K_QUOTE; n_state = ST_QUOTE;
                        end
                        CL_COMMENT: begin
                            delim = 1'b1; tok = 1'b1; kind = K_COMMENT;
                            n_state = ST_COMMENT;
                        end
                        CL_ESCAPE: begin
                            n_err = STS_ESCAPE; n_state = ST_HALT;
                        end
                        default: ;
                    endcase
                end
                ST_TOKEN, ST_AFTERQ: begin
                    case (i_item.cls)
                        CL_WHITE: begin
                            delim = 1'b1; n_state = ST_SEARCH;
                        end
                        CL_SEP: begin
                            delim = 1'b1; tok = 1'b1; kind = K_SEP; n_state = ST_SEP;
                        end
                        CL_COMMENT: begin
                            delim = 1'b1; tok = 1'b1; kind = K_COMMENT;
                            n_state = ST_COMMENT;
                        end
                        CL_QUOTE: begin
                            n_err = STS_QUOTE; n_state = ST_HALT;
                        end
                        CL_ESCAPE: begin
                            n_err = STS_ESCAPE; n_state = ST_HALT;
                        end
                        default: begin
                            if (r_state == ST_AFTERQ) begin
                                n_err = STS_CHAR; n_state = ST_HALT;
                            end
                        end
                    endcase
                end
                ST_QUOTE: begin
                    if (r_esc_pend) begin
                        n_esc_pend = 1'b0;
                    end else if ((i_item.is_dquote && r_dquote) ||
                                 (i_item.is_squote && !r_dquote)) begin
                        n_state = ST_AFTERQ;
                    end else if (i_item.cls == CL_ESCAPE) begin
                        n_esc_pend = 1'b1;
                    end
                end
                ST_SEP: begin
                    case (i_item.cls)
                        CL_WHITE: begin
                            delim = 1'b1; n_state = ST_SEARCH;
                        end
                        CL_SEP: begin
                            delim = 1'b1; tok = 1'b1; kind = K_SEP; n_state = ST_SEP;
                        end
                        CL_QUOTE: begin
                            delim = 1'b1; tok = 1'b1; kind = K_QUOTE; n_state = ST_QUOTE;
                            n_dquote = i_item.is_dquote;
                        end
                        CL_TOKEN: begin
                            delim = 1'b1; tok = 1'b1; kind = K_VALUE; n_state = ST_TOKEN;
                            n_ident = i_item.is_ident;
                        end
                        CL_COMMENT: begin
                            delim = 1'b1; tok = 1'b1; kind = K_COMMENT;
                            n_state = ST_COMMENT;
                        end
                        default: begin
                            n_err = STS_CLASS; n_state = ST_HALT;
                        end
                    endcase
                end
                default: begin
                    // comment runs to end of line
                    if (i_item.is_newline) begin
                        delim = 1'b1; n_state = ST_SEARCH;
                    end
                end
            endcase

            n_nl_pend = i_item.is_newline;
            n_line    = line_cur;
            n_col     = col_inc;

            // terminator before this character
            if (delim) begin
                res.put_terminator = 1'b1;
                n_last_char = 1'b0;
                n_buf_empty = 1'b0;
            end
            // new token record
            if (tok) begin
                n_tokens          = (r_tokens == '1) ? r_tokens : r_tokens + 1'b1;
                res.token_start   = 1'b1;
                res.token_kind    = kind;
                res.is_identifier = (kind == K_VALUE) && n_ident;
                res.start_line    = low16(32'(r_rec_line));
                res.start_column  = low16(32'(r_rec_col));
                n_rec_line        = line_cur;
                n_rec_col         = col_inc;
            end
            // character copied unless back to search
            if (n_state != ST_SEARCH) begin
                res.copy_char = 1'b1;
                n_last_char   = 1'b1;
                n_buf_empty   = 1'b0;
            end
            res.end_line    = low16(32'(line_cur));
            res.end_column  = low16(32'(col_cur));
            res.token_count = low16(32'(n_tokens));
            res.status      = n_err;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SEARCH;
            r_dquote    <= 1'b0;
            r_esc_pend  <= 1'b0;
            r_nl_pend   <= 1'b0;
            r_line      <= '0;
            r_col       <= '0;
            r_rec_line  <= '0;
            r_rec_col   <= '0;
            r_ident     <= 1'b0;
            r_tokens    <= '0;
            r_last_char <= 1'b0;
            r_buf_empty <= 1'b1;
            r_err       <= STS_PENDING;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_state     <= n_state;
                r_dquote    <= n_dquote;
                r_esc_pend  <= n_esc_pend;
                r_nl_pend   <= n_nl_pend;
                r_line      <= n_line;
                r_col       <= n_col;
                r_rec_line  <= n_rec_line;
                r_rec_col   <= n_rec_col;
                r_ident     <= n_ident;
                r_tokens    <= n_tokens;
                r_last_char <= n_last_char;
                r_buf_empty <= n_buf_empty;
                r_err       <= n_err;
            end
            r_out_valid <= pop || (r_out_valid && !i_res_ready);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

endmodule

>>> rtl/command_line_tokenizer_fsm_top.sv
`timescale 1ns / 1ps
// path: a byte taken in is held in the queue register, then in the lexer output register,
// before its result transfer; throughput one byte per cycle while the result side is ready
// one byte per cycle is set by the lexer state update in the back part
// the output register lets the queue keep taking bytes while a result waits
// reset: synchronous, active low; empties the queue, lexer back to search,
// counters zero, status pending
// ----------------------------------------------------------------------------
// command_line_tokenizer_fsm_top: streaming command line tokenizer
// Classifies each input byte, queues it, and runs the lexer to produce one
// result record per byte.
// ----------------------------------------------------------------------------
module command_line_tokenizer_fsm_top #(
    parameter int LINE_BITS   = clt_pkg::DEF_LINE_BITS,
    parameter int COLUMN_BITS = clt_pkg::DEF_COLUMN_BITS,
    parameter int COUNT_BITS  = clt_pkg::DEF_COUNT_BITS,
    parameter int QUEUE_DEPTH = clt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] put_terminator, [1] copy_char, [2] token_start, [4:3] token_kind,
    // [5] is_identifier, [21:6] start_line, [37:22] start_column,
    // [53:38] end_line, [69:54] end_column, [85:70] token_count,
    // [88:86] status, [95:89] zero
    output logic [95:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast    // string_done
);
    import clt_pkg::*;

    t_clt_item   push_item;
    t_clt_item   head_item;
    t_clt_result res;
    logic        push;
    logic        queue_full;
    logic        head_valid;
    logic        pop;

    // classify incoming bytes
    clt_front u_front (
        .i_valid      (i_s_axis_tvalid),
        .i_char       (i_s_axis_tdata),
        .i_queue_full (queue_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (push),
        .o_item       (push_item)
    );

    // decoupling queue
    clt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_item)
    );

    // lexer and result register
    clt_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (head_valid),
        .i_item       (head_item),
        .o_item_pop   (pop),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res)
    );

    // pack the result transfer
    assign o_m_axis_tdata = {7'd0, res.status, res.token_count, res.end_column,
                             res.end_line, res.start_column, res.start_line,
                             res.is_identifier, res.token_kind, res.token_start,
                             res.copy_char, res.put_terminator};
    assign o_m_axis_tlast = res.string_done;

endmodule

>>> tb/clt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_result_checker: lexer prediction and result comparison
// Watches byte transfers into the tokenizer, runs its own lexer model to
// predict one result record per byte, and compares every result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module clt_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] put_terminator, [1] copy_char, [2] token_start, [4:3] token_kind,
    // [5] is_identifier, [21:6] start_line, [37:22] start_column,
    // [53:38] end_line, [69:54] end_column, [85:70] token_count,
    // [88:86] status, [95:89] zero
    input  logic [95:0] i_m_axis_tdata,
    input  logic        i_m_axis_tlast,   // string_done
    output int          o_fail_count,
    output int          o_pending
);
    import clt_pkg::*;

    localparam int MAX_REPORTS = 40;

    // lexer model state
    logic [2:0]  lex_state;
    logic        dquote_open;
    logic        escape_armed;
    logic        newline_seen;
    logic [15:0] line_cnt;
    logic [15:0] col_cnt;
    logic [15:0] rec_line;
    logic [15:0] rec_col;
    logic        ident_first;
    logic [15:0] tokens_cnt;
    logic        last_was_char;
    logic        buf_empty;
    logic [2:0]  err_code;

    t_clt_result expected_results[$];
    t_clt_result want;
    t_clt_result got;
    t_clt_result predicted;
    int          mismatches;

    // counter step that sticks at all ones
    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // byte class as seen by the lexer
    function automatic logic [2:0] char_class(input logic [7:0] c);
        if (c <= CH_SPACE) return CL_WHITE;
        if (c == CH_DQUOTE || c == CH_SQUOTE) return CL_QUOTE;
        if (c == CH_BACKSLASH) return CL_ESCAPE;
        if (c == CH_HASH) return CL_COMMENT;
        case (c)
            ";", "=", "?", ".", "!", "@", "$", "%", "^", "&", "*", "+", "-",
            "~", 8'd96, "|", ":", ",", "/", "{", "}", "(", ")", "<", ">",
            "[", "]": return CL_SEP;
            default: return CL_TOKEN;
        endcase
    endfunction

    // letter or underscore opens an identifier
    function automatic logic ident_start(input logic [7:0] c);
        return (c == CH_UNDERSCORE) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    task automatic clear_lexer();
        lex_state     = ST_SEARCH;
        dquote_open   = 1'b0;
        escape_armed  = 1'b0;
        newline_seen  = 1'b0;
        line_cnt      = '0;
        col_cnt       = '0;
        rec_line      = '0;
        rec_col       = '0;
        ident_first   = 1'b0;
        tokens_cnt    = '0;
        last_was_char = 1'b0;
        buf_empty     = 1'b1;
        err_code      = STS_PENDING;
    endtask

    // one byte through the lexer, giving its result record
    task automatic lex_byte(input logic [7:0] c, output t_clt_result r);
        logic [2:0]  cls;
        logic [2:0]  nxt;
        logic [1:0]  kind;
        logic        delim;
        logic        tok;
        logic        is_nl;
        logic [15:0] cur_col;
        r     = '0;
        kind  = K_VALUE;
        delim = 1'b0;
        tok   = 1'b0;
        if (c == CH_NUL) begin
            // end of string: final status, then back to reset
            r.put_terminator = buf_empty || last_was_char;
            r.token_count    = tokens_cnt;
            r.status         = (lex_state == ST_HALT || lex_state == ST_QUOTE) ?
                               err_code : STS_OK;
            r.string_done    = 1'b1;
            clear_lexer();
        end else if (lex_state == ST_HALT) begin
            // halted after an error: byte is dropped
            r.token_count = tokens_cnt;
            r.status      = err_code;
        end else begin
            if (newline_seen) begin
                line_cnt     = sat16(line_cnt);
                col_cnt      = '0;
                newline_seen = 1'b0;
            end
            cur_col = col_cnt;
            cls     = char_class(c);
            is_nl   = (c == CH_NEWLINE);
            nxt     = lex_state;
            case (lex_state)
                ST_SEARCH: begin
                    if (cls == CL_TOKEN) begin
                        tok = 1'b1; kind = K_VALUE; nxt = ST_TOKEN;
                        ident_first = ident_start(c);
                    end else if (cls == CL_SEP) begin
                        delim = 1'b1; tok = 1'b1; kind = K_SEP; nxt = ST_SEP;
                    end else if (cls == CL_QUOTE) begin
                        dquote_open = (c == CH_DQUOTE);
                        tok = 1'b1; kind = K_QUOTE; nxt = ST_QUOTE;
                    end else if (cls == CL_COMMENT) begin
                        delim = 1'b1; tok = 1'b1; kind = K_COMMENT; nxt = ST_COMMENT;
                    end else if (cls == CL_ESCAPE) begin
                        err_code = STS_ESCAPE; nxt = ST_HALT;
                    end
                end
                ST_TOKEN, ST_AFTERQ: begin
                    if (cls == CL_WHITE) begin
                        delim = 1'b1; nxt = ST_SEARCH;
                    end else if (cls == CL_SEP) begin
                        delim = 1'b1; tok = 1'b1; kind = K_SEP; nxt = ST_SEP;
                    end else if (cls == CL_COMMENT) begin
                        delim = 1'b1; tok = 1'b1; kind = K_COMMENT; nxt = ST_COMMENT;
                    end else if (cls == CL_QUOTE) begin
                        err_code = STS_QUOTE; nxt = ST_HALT;
                    end else if (cls == CL_ESCAPE) begin
                        err_code = STS_ESCAPE; nxt = ST_HALT;
                    end else if (lex_state == ST_AFTERQ) begin
                        // token byte glued to a closing quote
                        err_code = STS_CHAR; nxt = ST_HALT;
                    end
                end
                ST_QUOTE: begin
                    if (escape_armed) begin
                        escape_armed = 1'b0;
                    end else if ((c == CH_DQUOTE && dquote_open) ||
                                 (c == CH_SQUOTE && !dquote_open)) begin
                        nxt = ST_AFTERQ;
                    end else if (cls == CL_ESCAPE) begin
                        escape_armed = 1'b1;
                    end
                end
                ST_SEP: begin
                    if (cls == CL_WHITE) begin
                        delim = 1'b1; nxt = ST_SEARCH;
                    end else if (cls == CL_SEP) begin
                        delim = 1'b1; tok = 1'b1; kind = K_SEP; nxt = ST_SEP;
                    end else if (cls == CL_QUOTE) begin
                        delim = 1'b1; tok = 1'b1; kind = K_QUOTE; nxt = ST_QUOTE;
                        dquote_open = (c == CH_DQUOTE);
                    end else if (cls == CL_TOKEN) begin
                        delim = 1'b1; tok = 1'b1; kind = K_VALUE; nxt = ST_TOKEN;
                        ident_first = ident_start(c);
                    end else if (cls == CL_COMMENT) begin
                        delim = 1'b1; tok = 1'b1; kind = K_COMMENT; nxt = ST_COMMENT;
                    end else begin
                        // escape right after a separator
                        err_code = STS_CLASS; nxt = ST_HALT;
                    end
                end
                default: begin
                    // comment runs to the newline
                    if (is_nl) begin
                        delim = 1'b1; nxt = ST_SEARCH;
                    end
                end
            endcase
            lex_state    = nxt;
            newline_seen = is_nl;

            if (delim) begin
                r.put_terminator = 1'b1;
                last_was_char    = 1'b0;
                buf_empty        = 1'b0;
            end
            if (tok) begin
                tokens_cnt      = sat16(tokens_cnt);
                r.token_start   = 1'b1;
                r.token_kind    = kind;
                r.is_identifier = (kind == K_VALUE) && ident_first;
                r.start_line    = rec_line;
                r.start_column  = rec_col;
                rec_line        = line_cnt;
                rec_col         = sat16(cur_col);
            end
            if (nxt != ST_SEARCH) begin
                r.copy_char   = 1'b1;
                last_was_char = 1'b1;
                buf_empty     = 1'b0;
            end
            r.end_line    = line_cnt;
            r.end_column  = cur_col;
            r.token_count = tokens_cnt;
            r.status      = err_code;
            col_cnt       = sat16(cur_col);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    // compare result transfers, then predict from byte transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lexer();
            expected_results.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.put_terminator = i_m_axis_tdata[0];
                got.copy_char      = i_m_axis_tdata[1];
                got.token_start    = i_m_axis_tdata[2];
                got.token_kind     = i_m_axis_tdata[4:3];
                got.is_identifier  = i_m_axis_tdata[5];
                got.start_line     = i_m_axis_tdata[21:6];
                got.start_column   = i_m_axis_tdata[37:22];
                got.end_line       = i_m_axis_tdata[53:38];
                got.end_column     = i_m_axis_tdata[69:54];
                got.token_count    = i_m_axis_tdata[85:70];
                got.status         = i_m_axis_tdata[88:86];
                got.string_done    = i_m_axis_tlast;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t ns: unexpected result, expected none actual %h",
                                 $time, i_m_axis_tdata);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("put_terminator", want.put_terminator, got.put_terminator);
                    check_field("copy_char", want.copy_char, got.copy_char);
                    check_field("token_start", want.token_start, got.token_start);
                    check_field("token_kind", want.token_kind, got.token_kind);
                    check_field("is_identifier", want.is_identifier, got.is_identifier);
                    check_field("start_line", want.start_line, got.start_line);
                    check_field("start_column", want.start_column, got.start_column);
                    check_field("end_line", want.end_line, got.end_line);
                    check_field("end_column", want.end_column, got.end_column);
                    check_field("token_count", want.token_count, got.token_count);
                    check_field("status", want.status, got.status);
                    check_field("string_done", want.string_done, got.string_done);
                    check_field("pad", 16'd0, {9'd0, i_m_axis_tdata[95:89]});
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                lex_byte(i_s_axis_tdata, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        clear_lexer();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the command line tokenizer
// Feeds directed strings and then random, mostly well formed command lines
// (words, separators, quoted text with escapes, comments, noise) under random
// idling on both sides, and leaves the checking to the result checker.
// ----------------------------------------------------------------------------
module tb_top;
    import clt_pkg::*;

    localparam int TOTAL_BYTES = 650;
    localparam int CALM_AFTER  = 560;
    localparam int HOLD_AT     = 200;
    localparam int PAUSE_AT    = 420;
    localparam int HOLD_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int          bytes_sent;
    logic        src_idle_on;
    logic        sink_idle_on;
    logic        hold_req;
    logic        did_hold;
    logic        did_pause;

    command_line_tokenizer_fsm_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    clt_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] c);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return 8'd9;
            2: return CH_NEWLINE;
            default: return 8'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 26))
            0: return CH_SEMICOLON;  1: return "=";  2: return "?";  3: return ".";
            4: return "!";  5: return "@";  6: return "$";  7: return "%";
            8: return "^";  9: return "&"; 10: return "*"; 11: return "+";
            12: return "-"; 13: return "~"; 14: return 8'd96; 15: return "|";
            16: return ":"; 17: return ","; 18: return "/"; 19: return "{";
            20: return "}"; 21: return "("; 22: return ")"; 23: return "<";
            24: return ">"; 25: return "[";
            default: return "]";
        endcase
    endfunction

    // letter or underscore
    function automatic logic [7:0] pick_ident_char();
        int n;
        n = $urandom_range(0, 52);
        if (n < 26) return 8'd65 + 8'(n);
        if (n < 52) return 8'd97 + 8'(n - 26);
        return CH_UNDERSCORE;
    endfunction

    // byte that continues a value token; high bytes included
    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0: return 8'd48 + 8'($urandom_range(0, 9));
            1: return 8'($urandom_range(128, 255));
            default: return pick_ident_char();
        endcase
    endfunction

    // one lexical piece of a command line
    task automatic gen_piece();
        int          n;
        logic [7:0]  q;
        logic [7:0]  b;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                send_byte(pick_ident_char());
                repeat ($urandom_range(0, 5)) send_byte(pick_word_char());
            end
            5, 6: begin
                repeat ($urandom_range(1, 4)) send_byte(pick_word_char());
            end
            7, 8, 9: begin
                repeat ($urandom_range(1, 2)) send_byte(pick_separator());
            end
            10, 11, 12: begin
                // quoted text with escapes, properly closed
                q = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
                send_byte(q);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    b = 8'($urandom_range(1, 255));
                    if (b == q || b == CH_BACKSLASH) send_byte(CH_BACKSLASH);
                    send_byte(b);
                    if ($urandom_range(0, 3) == 0) begin
                        send_byte(CH_BACKSLASH);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                end
                send_byte(q);
                if ($urandom_range(0, 2) == 0) send_byte(pick_separator());
            end
            13, 14: begin
                send_byte(CH_HASH);
                repeat ($urandom_range(0, 5)) begin
                    b = 8'($urandom_range(1, 255));
                    send_byte((b == CH_NEWLINE) ? CH_HASH : b);
                end
                send_byte(CH_NEWLINE);
            end
            15, 16: begin
                repeat ($urandom_range(1, 3)) send_byte(pick_space());
            end
            17: begin
                // noise
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)));
            end
            18: begin
                // broken sequences
                case ($urandom_range(0, 3))
                    0: send_byte(CH_BACKSLASH);
                    1: begin
                        send_byte(pick_word_char());
                        send_byte(($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE);
                    end
                    2: begin
                        send_byte(CH_SQUOTE);
                        send_byte(CH_SQUOTE);
                        send_byte(pick_word_char());
                    end
                    default: begin
                        send_byte(pick_separator());
                        send_byte(CH_BACKSLASH);
                    end
                endcase
            end
            default: begin
                // quote left open
                send_byte(CH_DQUOTE);
                repeat ($urandom_range(0, 3)) send_byte(pick_word_char());
            end
        endcase
        if ($urandom_range(0, 9) < 7) send_byte(pick_space());
    endtask

    // stimulus
    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        bytes_sent   = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        did_hold     = 1'b0;
        did_pause    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // empty string
        send_byte(CH_NUL);
        // identifier, high byte, separator, escaped quote, comment, new line
        send_byte(CH_UNDERSCORE); send_byte(8'hFF); send_byte("=");
        send_byte(CH_DQUOTE); send_byte(CH_BACKSLASH); send_byte(CH_DQUOTE);
        send_byte(CH_DQUOTE); send_byte(CH_HASH); send_byte(CH_NEWLINE);
        send_byte("A"); send_byte(CH_NUL);
        // escape while searching, then a dropped byte
        send_byte(CH_BACKSLASH); send_byte("z"); send_byte(CH_NUL);
        // quote right after a word
        send_byte("a"); send_byte(CH_SQUOTE); send_byte(CH_NUL);
        // word byte right after a closing quote
        send_byte(CH_SQUOTE); send_byte(CH_SQUOTE); send_byte("b"); send_byte(CH_NUL);
        // escape right after a separator
        send_byte(CH_SEMICOLON); send_byte(CH_BACKSLASH); send_byte(CH_NUL);
        // quote still open at the end
        send_byte(CH_DQUOTE); send_byte(CH_NUL);

        // random command lines
        while (bytes_sent < TOTAL_BYTES) begin
            if (bytes_sent >= CALM_AFTER) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (!did_hold && bytes_sent >= HOLD_AT) begin
                hold_req = 1'b1;
                did_hold = 1'b1;
            end
            if (!did_pause && bytes_sent >= PAUSE_AT) begin
                s_tvalid = 1'b0;
                do @(negedge clk); while (pending != 0);
                did_pause = 1'b1;
            end
            repeat ($urandom_range(1, 6)) gen_piece();
            send_byte(CH_NUL);
        end
        s_tvalid = 1'b0;

        // drain
        do @(negedge clk); while (pending != 0);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result side: random stalls and one long hold-off
    initial begin
        m_tready = 1'b0;
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end else begin
                m_tready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
